FILE: hw/rtl/pkwec_pkg.sv
`default_nettype none
package pkwec_pkg;

    localparam int NCOUNT = 16;

    localparam logic [3:0] ADDR_WINDOW = 4'd0;

    localparam logic [2:0] ST_UPDATED    = 3'd0;
    localparam logic [2:0] ST_RESTARTED  = 3'd1;
    localparam logic [2:0] ST_ALLOCATED  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_REPORTED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

    localparam logic [2:0] EV_EXEC    = 3'd0;
    localparam logic [2:0] EV_SYSCALL = 3'd1;
    localparam logic [2:0] EV_PKT_OUT = 3'd2;
    localparam logic [2:0] EV_PKT_IN  = 3'd3;
    localparam logic [2:0] EV_DNS     = 3'd4;

    localparam logic [3:0] SUB_CLONE   = 4'd4;
    localparam logic [3:0] SUB_UNSHARE = 4'd5;
    localparam logic [3:0] SUB_SETNS   = 4'd6;
    localparam logic [3:0] SUB_SOCKET  = 4'd7;
    localparam logic [3:0] SUB_OTHER   = 4'd8;

    localparam logic [3:0] C_EXEC      = 4'd0;
    localparam logic [3:0] C_NAMESPACE = 4'd6;
    localparam logic [3:0] C_SOCKET    = 4'd7;
    localparam logic [3:0] C_PKT_OUT   = 4'd8;
    localparam logic [3:0] C_LEN       = 4'd9;
    localparam logic [3:0] C_DST_IPS   = 4'd10;
    localparam logic [3:0] C_DST_PORTS = 4'd11;
    localparam logic [3:0] C_SYN       = 4'd12;
    localparam logic [3:0] C_SUSP      = 4'd13;
    localparam logic [3:0] C_PKT_IN    = 4'd14;
    localparam logic [3:0] C_DNS       = 4'd15;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] FLAG_SYN  = 8'h02;
    localparam logic [7:0] FLAG_ACK  = 8'h10;

    localparam logic [63:0] WINDOW_RESET = 64'd1000000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SEARCH_WAIT,
        S_DECIDE,
        S_TIME,
        S_UPD_READ,
        S_UPD_WAIT,
        S_UPD_WRITE,
        S_RD_READ,
        S_RD_WAIT,
        S_RD_OUT,
        S_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic scan_clear;
        logic scan_step;
        logic cnt_clear;
        logic cnt_step;
        logic claim;
        logic restart;
        logic cnt_write;
        logic load_result;
        logic [2:0] result_status;
        logic result_last;
        logic load_report;
        logic use_slot;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic kind;
        logic scan_done;
        logic found;
        logic free_found;
        logic expired;
        logic cnt_done;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pkwec_ctrl.sv
`default_nettype none
module pkwec_ctrl
    import pkwec_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    // advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:        if (in_valid) state_next = S_SEARCH;
            S_SEARCH:      state_next = S_SEARCH_WAIT;
            S_SEARCH_WAIT: state_next = st.scan_done ? S_DECIDE : S_SEARCH_WAIT;
            S_DECIDE:
            begin
                if (st.kind)
                    state_next = st.found ? S_RD_READ : S_RESULT;
                else if (st.found)
                    state_next = S_TIME;
                else if (st.free_found)
                    state_next = S_UPD_READ;
                else
                    state_next = S_RESULT;
            end
            S_TIME:        state_next = S_UPD_READ;
            S_UPD_READ:    state_next = S_UPD_WAIT;
            S_UPD_WAIT:    state_next = S_UPD_WRITE;
            S_UPD_WRITE:   state_next = st.cnt_done ? S_RESULT : S_UPD_READ;
            S_RD_READ:     state_next = S_RD_WAIT;
            S_RD_WAIT:     state_next = S_RD_OUT;
            S_RD_OUT:
            begin
                if (!st.out_busy)
                    state_next = st.cnt_done ? S_IDLE : S_RD_READ;
            end
            S_RESULT:      if (!st.out_busy) state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    // outputs
    logic restart_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg <= 1'b0;
        end
        else if (state_reg == S_DECIDE)
        begin
            restart_reg <= 1'b0;
        end
        else if (state_reg == S_TIME)
        begin
            restart_reg <= st.expired;
        end
    end

    // a read never claims a slot
    logic alloc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= 1'b0;
        end
        else if (state_reg == S_DECIDE)
        begin
            alloc_reg <= !st.kind && !st.found && st.free_found;
        end
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_item = in_valid;
            end
            S_SEARCH: cmd.scan_clear = 1'b1;
            S_SEARCH_WAIT: cmd.scan_step = !st.scan_done;
            S_DECIDE:
            begin
                cmd.cnt_clear = 1'b1;
                cmd.claim = !st.kind && !st.found && st.free_found;
            end
            S_TIME: cmd.restart = st.expired;
            S_UPD_WRITE:
            begin
                cmd.cnt_write = 1'b1;
                cmd.cnt_step = 1'b1;
            end
            S_RD_OUT:
            begin
                cmd.load_report = !st.out_busy;
                cmd.cnt_step = !st.out_busy;
            end
            S_RESULT:
            begin
                cmd.load_result = !st.out_busy;
                cmd.result_last = 1'b1;
                cmd.use_slot = st.found || alloc_reg;
                if (st.kind)
                    cmd.result_status = ST_NOT_FOUND;
                else if (alloc_reg)
                    cmd.result_status = ST_ALLOCATED;
                else if (!st.found)
                    cmd.result_status = ST_FULL;
                else if (restart_reg)
                    cmd.result_status = ST_RESTARTED;
                else
                    cmd.result_status = ST_UPDATED;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/pkwec_dp.sv
`default_nettype none
module pkwec_dp
    import pkwec_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output stat_t            st,
    input  wire logic [63:0] window_length_ns,
    input  wire logic        kind,
    input  wire logic [31:0] process_id,
    input  wire logic [63:0] timestamp_ns,
    input  wire logic [2:0]  event_code,
    input  wire logic [3:0]  syscall_subtype,
    input  wire logic [15:0] packet_length,
    input  wire logic [7:0]  ip_protocol,
    input  wire logic [7:0]  tcp_flags,
    input  wire logic [15:0] destination_port,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [5:0]       slot_index,
    output logic [3:0]       counter_index,
    output logic [31:0]      counter_value,
    output logic             last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;

    // captured item
    logic        kind_reg;
    logic [31:0] key_reg;
    logic [63:0] ts_reg;
    logic [2:0]  etype_reg;
    logic [3:0]  sub_reg;
    logic [15:0] plen_reg;
    logic [7:0]  proto_reg;
    logic [7:0]  flags_reg;
    logic [15:0] dport_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= kind;
            key_reg   <= process_id;
            ts_reg    <= timestamp_ns;
            etype_reg <= event_code;
            sub_reg   <= syscall_subtype;
            plen_reg  <= packet_length;
            proto_reg <= ip_protocol;
            flags_reg <= tcp_flags;
            dport_reg <= destination_port;
        end
    end

    // slot tables
    logic [SLOTS-1:0] active_reg;
    logic [31:0] key_mem [SLOTS];
    logic [63:0] start_mem [SLOTS];
    logic [COUNTER_BITS-1:0] cnt_mem [SLOTS*NCOUNT];

    logic [CW-1:0] scan_reg;
    logic [SW-1:0] slot_reg;
    logic found_reg, free_reg, done_reg;
    logic [SW-1:0] free_slot_reg;
    logic [31:0] key_rd_reg;
    logic [63:0] start_rd_reg;
    logic scan_vld_reg;
    logic [SW-1:0] scan_idx_reg;
    logic scan_act_reg;

    // scan slots one per cycle, key read registered
    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[scan_reg[SW-1:0]];
        start_rd_reg <= start_mem[slot_reg];
        scan_idx_reg <= scan_reg[SW-1:0];
        scan_act_reg <= active_reg[scan_reg[SW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            scan_vld_reg <= 1'b0;
            found_reg <= 1'b0;
            free_reg <= 1'b0;
            done_reg <= 1'b0;
            slot_reg <= '0;
            free_slot_reg <= '0;
        end
        else if (cmd.scan_clear)
        begin
            scan_reg <= '0;
            scan_vld_reg <= 1'b0;
            found_reg <= 1'b0;
            free_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_vld_reg <= (scan_reg < CW'(SLOTS));
            if (scan_reg < CW'(SLOTS))
                scan_reg <= scan_reg + 1'b1;
            if (scan_vld_reg)
            begin
                if (scan_act_reg && key_rd_reg == key_reg)
                begin
                    found_reg <= 1'b1;
                    slot_reg <= scan_idx_reg;
                    done_reg <= 1'b1;
                end
                else if (!scan_act_reg && !free_reg)
                begin
                    free_reg <= 1'b1;
                    free_slot_reg <= scan_idx_reg;
                end
                if (scan_idx_reg == SW'(SLOTS - 1))
                    done_reg <= 1'b1;
            end
        end
        else if (cmd.claim)
        begin
            slot_reg <= free_slot_reg;
        end
    end

    // expiry check on the found slot's window
    logic [63:0] age;
    assign age = ts_reg - start_rd_reg;

    // open or restart a window
    logic clear_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            clear_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clear)
                clear_reg <= 1'b0;
            if (cmd.claim)
            begin
                active_reg[free_slot_reg] <= 1'b1;
                clear_reg <= 1'b1;
            end
            if (cmd.restart)
                clear_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
        begin
            key_mem[free_slot_reg] <= key_reg;
            start_mem[free_slot_reg] <= ts_reg;
        end
        else if (cmd.restart)
        begin
            start_mem[slot_reg] <= ts_reg;
        end
    end

    // counter walk, read-modify-write per counter
    logic [3:0] ci_reg;
    logic [COUNTER_BITS-1:0] crd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg <= '0;
        end
        else if (cmd.cnt_clear)
        begin
            ci_reg <= '0;
        end
        else if (cmd.cnt_step)
        begin
            ci_reg <= ci_reg + 1'b1;
        end
    end

    logic [SW+3:0] caddr;
    assign caddr = {slot_reg, ci_reg};

    always_ff @(posedge clk)
    begin
        crd_reg <= cnt_mem[caddr];
    end

    // increment amount for the current counter
    logic [15:0] amount;
    logic susp;
    assign susp = (dport_reg < 16'd1024) || (dport_reg == 16'd4444)
                  || (dport_reg == 16'd1337) || (dport_reg == 16'd31337);
    always_comb
    begin
        amount = '0;
        case (etype_reg)
            EV_EXEC: if (ci_reg == C_EXEC) amount = 16'd1;
            EV_SYSCALL:
            begin
                if (sub_reg <= SUB_CLONE && ci_reg == sub_reg + 4'd1)
                    amount = 16'd1;
                else if ((sub_reg == SUB_UNSHARE || sub_reg == SUB_SETNS)
                         && ci_reg == C_NAMESPACE)
                    amount = 16'd1;
                else if (sub_reg == SUB_SOCKET && ci_reg == C_SOCKET)
                    amount = 16'd1;
            end
            EV_PKT_OUT:
            begin
                if (ci_reg == C_PKT_OUT || ci_reg == C_DST_IPS
                    || ci_reg == C_DST_PORTS)
                    amount = 16'd1;
                else if (ci_reg == C_LEN)
                    amount = plen_reg;
                else if (ci_reg == C_SYN && proto_reg == PROTO_TCP
                         && (flags_reg & FLAG_SYN) != 8'd0
                         && (flags_reg & FLAG_ACK) == 8'd0)
                    amount = 16'd1;
                else if (ci_reg == C_SUSP && susp)
                    amount = 16'd1;
            end
            EV_PKT_IN: if (ci_reg == C_PKT_IN) amount = 16'd1;
            EV_DNS:    if (ci_reg == C_DNS) amount = 16'd1;
            default: ;
        endcase
    end

    logic [COUNTER_BITS-1:0] base;
    logic [COUNTER_BITS:0] sum;
    assign base = clear_reg ? '0 : crd_reg;
    assign sum = {1'b0, base} + (COUNTER_BITS+1)'(amount);

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_write)
            cnt_mem[caddr] <= sum[COUNTER_BITS] ? CMAX : sum[COUNTER_BITS-1:0];
    end

    // output register
    logic [31:0] rep_val;
    generate
        if (COUNTER_BITS > 32)
        begin : g_wide
            assign rep_val = (crd_reg[COUNTER_BITS-1:32] != '0) ? 32'hFFFFFFFF
                                                                : crd_reg[31:0];
        end
        else
        begin : g_narrow
            assign rep_val = 32'(crd_reg);
        end
    endgenerate

    logic [5:0] slot6;
    assign slot6 = 6'(slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cmd.load_result || cmd.load_report)
                out_valid <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            status <= cmd.result_status;
            slot_index <= cmd.use_slot ? slot6 : 6'd0;
            counter_index <= '0;
            counter_value <= '0;
            last <= cmd.result_last;
        end
        else if (cmd.load_report)
        begin
            status <= ST_REPORTED;
            slot_index <= slot6;
            counter_index <= ci_reg;
            counter_value <= rep_val;
            last <= (ci_reg == 4'd15);
        end
    end

    assign st.kind = kind_reg;
    assign st.scan_done = done_reg;
    assign st.found = found_reg;
    assign st.free_found = free_reg;
    assign st.expired = age > window_length_ns;
    assign st.cnt_done = (ci_reg == 4'd15);
    assign st.out_busy = out_valid && !out_ready;

    // a new result never overwrites an unaccepted one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_result || cmd.load_report) |-> !(out_valid && !out_ready))
        else $error("result overwritten");
    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |-> !active_reg[free_slot_reg])
        else $error("claimed active slot");
    a_write_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_write |-> (found_reg || $past(active_reg[slot_reg])
                           || active_reg[slot_reg]))
        else $error("counter write to inactive slot");

endmodule
`default_nettype wire

FILE: hw/rtl/per_key_windowed_event_counters.sv
// Channel | Signals                                    | Direction
// in      | in_valid/in_ready, kind..destination_port  | input items
// out     | out_valid/out_ready, status..last          | result beats
// cfg     | APB psel/penable/pwrite/paddr/pwdata        | window_length_ns
// Slot search checks one slot per cycle, set by the single key-table read
// port; then a decide step, a window check on a record an update found, a
// read, wait and write (update) or report (found read) step per counter over
// the 16 counters, and a result beat, except after a found read's reports.
// Of the slot tables, reset clears the active bits only; no clearing pass is needed.
// A stalled output beat holds a read's report walk until it is taken.
`default_nettype none
module per_key_windowed_event_counters
    import pkwec_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [31:0] process_id,
    input  wire logic [63:0] timestamp_ns,
    input  wire logic [2:0]  event_code,
    input  wire logic [3:0]  syscall_subtype,
    input  wire logic [15:0] packet_length,
    input  wire logic [7:0]  ip_protocol,
    input  wire logic [7:0]  tcp_flags,
    input  wire logic [15:0] destination_port,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [5:0]       slot_index,
    output logic [3:0]       counter_index,
    output logic [31:0]      counter_value,
    output logic             last
);

    logic [63:0] window_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_WINDOW)
        begin
            window_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW) ? window_reg : 64'd0;

    cmd_t  cmd;
    stat_t st;

    pkwec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    pkwec_dp #(
        .SLOTS        (SLOTS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .window_length_ns (window_reg),
        .kind             (kind),
        .process_id       (process_id),
        .timestamp_ns     (timestamp_ns),
        .event_code       (event_code),
        .syscall_subtype  (syscall_subtype),
        .packet_length    (packet_length),
        .ip_protocol      (ip_protocol),
        .tcp_flags        (tcp_flags),
        .destination_port (destination_port),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .slot_index       (slot_index),
        .counter_index    (counter_index),
        .counter_value    (counter_value),
        .last             (last)
    );

endmodule
`default_nettype wire
